// File: rtl/ssag_pkg.sv
// Shared types and constants for the strided scatter address generator.
package ssag_pkg;

  localparam int ELEM_W     = 64;
  localparam int OUT_ADDR_W = 48;
  localparam int BASE_W     = 48;
  localparam int CNT_REG_W  = 16;
  localparam int STRIDE_W   = 32;
  localparam int LG_W       = 2;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DST_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE_LOG2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_OUTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MIDDLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_INNER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_OUTER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_MIDDLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_INNER   = 3'd7;

  // Dimension numbering along the cell chain, inner first.
  localparam int DIM_INNER  = 0;
  localparam int DIM_MIDDLE = 1;
  localparam int DIM_OUTER  = 2;
  localparam int NUM_DIMS   = 3;

  // Per-dimension settings handed to one cell.
  typedef struct packed {
    logic [CNT_REG_W-1:0] count;
    logic [STRIDE_W-1:0]  stride;
    logic [LG_W-1:0]      size_log2;
  } cell_cfg_t;

endpackage

// File: rtl/ssag_elem_if.sv
// Channel carrying source elements into the block.
interface ssag_elem_if;
  import ssag_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] elem_data;

  modport source (output valid, output elem_data, input ready);
  modport sink (input valid, input elem_data, output ready);
endinterface

// File: rtl/ssag_result_if.sv
// Channel carrying elements with their destination addresses out of the block.
interface ssag_result_if;
  import ssag_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] dst_addr;
  logic [ELEM_W-1:0]     elem_out;
  logic                  last_elem;

  modport source (output valid, output dst_addr, output elem_out, output last_elem,
                  input ready);
  modport sink (input valid, input dst_addr, input elem_out, input last_elem,
                output ready);
endinterface

// File: rtl/ssag_cell.sv
// One dimension cell: position counter and byte offset, carry passed outward.
module ssag_cell #(
  parameter int ADDR_WIDTH  = 48,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  ssag_pkg::cell_cfg_t   cfg,
  input  logic                  carry_in,
  output logic                  carry_out,
  output logic [ADDR_WIDTH-1:0] offset
);
  import ssag_pkg::*;

  logic [COUNT_WIDTH-1:0] pos;
  logic [COUNT_WIDTH-1:0] pos_next;
  logic [ADDR_WIDTH-1:0]  off;
  logic [ADDR_WIDTH-1:0]  off_next;

  logic [31:0]            cnt32;
  logic [COUNT_WIDTH-1:0] n_raw;
  logic [COUNT_WIDTH:0]   n_eff;
  logic [COUNT_WIDTH:0]   pos_inc;
  logic                   at_end;
  logic signed [63:0]     stride_ext;
  logic [63:0]            step_full;
  logic [ADDR_WIDTH-1:0]  step;

  always_comb begin
    cnt32   = 32'(cfg.count);
    n_raw   = cnt32[COUNT_WIDTH-1:0];
    // zero count behaves as one
    n_eff   = (n_raw == '0) ? (COUNT_WIDTH+1)'(1) : {1'b0, n_raw};
    pos_inc = {1'b0, pos} + (COUNT_WIDTH+1)'(1);
    at_end  = (pos_inc >= n_eff);
    carry_out = carry_in && at_end;

    stride_ext = 64'(signed'(cfg.stride));
    step_full  = 64'(stride_ext) << cfg.size_log2;
    step       = step_full[ADDR_WIDTH-1:0];

    pos_next = pos;
    off_next = off;
    if (advance && carry_in) begin
      if (at_end) begin
        pos_next = '0;
        off_next = '0;
      end else begin
        pos_next = pos_inc[COUNT_WIDTH-1:0];
        off_next = off + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      off <= '0;
    end else begin
      pos <= pos_next;
      off <= off_next;
    end
  end

  assign offset = off;

endmodule

// File: rtl/strided_scatter_address_generator_unit.sv
// Top level of the strided scatter address generator.
// Takes one source element per request in row-major order and returns it with its
// destination byte address: dst_base plus, per dimension, position * stride * element
// size, modulo 2^ADDR_WIDTH, shown on the 48-bit dst_addr. A chain of MAX_DIMS
// cells (inner first) holds the positions and offsets; a wrap of one cell carries
// into the next, and last_elem marks the element whose carry leaves the outermost
// cell, after which every cell is back at zero. Throughput is one element per clock
// unless result.ready stalls it; each result shows in the cycle after its request is
// accepted, from a single output register fed by the carry ripple and base+offset sum.
// Configuration writes go to cfg_index/cfg_data with cfg_we; write only when idle.
module strided_scatter_address_generator_unit #(
  parameter int MAX_DIMS    = 3,
  parameter int ADDR_WIDTH  = 48,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssag_pkg::CFG_DATA_W-1:0]     cfg_data,
  ssag_elem_if.sink                           elem,
  ssag_result_if.source                       result
);
  import ssag_pkg::*;

  logic [BASE_W-1:0]    dst_base;
  logic [LG_W-1:0]      elem_size_log2;
  logic [CNT_REG_W-1:0] count_reg [NUM_DIMS];
  logic [STRIDE_W-1:0]  stride_reg [NUM_DIMS];

  cell_cfg_t             cell_cfg [MAX_DIMS];
  logic                  carry [MAX_DIMS+1];
  logic [ADDR_WIDTH-1:0] offs [MAX_DIMS];
  logic [ADDR_WIDTH-1:0] addr_sum;
  logic [ADDR_WIDTH-1:0] offs_or;
  logic                  accept;

  logic                  out_valid;
  logic [OUT_ADDR_W-1:0] out_addr;
  logic [ELEM_W-1:0]     out_elem;
  logic                  out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_base               <= '0;
      elem_size_log2         <= '0;
      count_reg[DIM_OUTER]   <= CNT_REG_W'(1);
      count_reg[DIM_MIDDLE]  <= CNT_REG_W'(1);
      count_reg[DIM_INNER]   <= CNT_REG_W'(1);
      stride_reg[DIM_OUTER]  <= '0;
      stride_reg[DIM_MIDDLE] <= '0;
      stride_reg[DIM_INNER]  <= STRIDE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DST_BASE:       dst_base               <= cfg_data[BASE_W-1:0];
        REG_ELEM_SIZE_LOG2: elem_size_log2         <= cfg_data[LG_W-1:0];
        REG_COUNT_OUTER:    count_reg[DIM_OUTER]   <= cfg_data[CNT_REG_W-1:0];
        REG_COUNT_MIDDLE:   count_reg[DIM_MIDDLE]  <= cfg_data[CNT_REG_W-1:0];
        REG_COUNT_INNER:    count_reg[DIM_INNER]   <= cfg_data[CNT_REG_W-1:0];
        REG_STRIDE_OUTER:   stride_reg[DIM_OUTER]  <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_MIDDLE:  stride_reg[DIM_MIDDLE] <= cfg_data[STRIDE_W-1:0];
        REG_STRIDE_INNER:   stride_reg[DIM_INNER]  <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = elem.valid && elem.ready;
  assign elem.ready = !out_valid || result.ready;

  // inner cell steps on every accepted element; each wrap carries outward
  assign carry[0] = 1'b1;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    always_comb begin
      cell_cfg[d].count     = count_reg[d];
      cell_cfg[d].stride    = stride_reg[d];
      cell_cfg[d].size_log2 = elem_size_log2;
    end

    ssag_cell #(
      .ADDR_WIDTH  (ADDR_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (accept),
      .cfg       (cell_cfg[d]),
      .carry_in  (carry[d]),
      .carry_out (carry[d+1]),
      .offset    (offs[d])
    );
  end

  always_comb begin
    addr_sum = ADDR_WIDTH'(dst_base);
    offs_or  = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      addr_sum = addr_sum + offs[d];
      offs_or  = offs_or | offs[d];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (elem.ready) begin
      out_valid <= elem.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_addr <= OUT_ADDR_W'(addr_sum);
      out_elem <= elem.elem_data;
      out_last <= carry[MAX_DIMS];
    end
  end

  assign result.valid     = out_valid;
  assign result.dst_addr  = out_addr;
  assign result.elem_out  = out_elem;
  assign result.last_elem = out_last;

`ifndef SYNTHESIS
  a_wrap_clears_offsets: assert property (@(posedge clk) disable iff (rst)
    accept && carry[MAX_DIMS] |=> offs_or == '0)
    else $error("offsets not cleared after final element");

  a_last_follows_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && carry[MAX_DIMS] |=> result.valid && result.last_elem)
    else $error("final element not flagged");

  a_request_yields_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted request produced no result");
`endif

endmodule

// File: tb/sv/strided_scatter_address_generator_unit_test.sv
// Self-checking testbench for the strided scatter address generator.
module strided_scatter_address_generator_unit_test;
  import ssag_pkg::*;

  localparam int TARGET_ELEMS = 850;
  localparam int HOLD_CYCLES  = 80;
  // no request accepted on either side for this long means a hang
  localparam int IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] addr;
    logic [ELEM_W-1:0]     data;
    logic                  last;
  } placement_t;

  // Tracks the address counters and holds the placements still owed by the block.
  class placement_scoreboard;
    logic [BASE_W-1:0]     base;
    logic [LG_W-1:0]       size_lg;
    logic [CNT_REG_W-1:0]  count [NUM_DIMS];
    logic [STRIDE_W-1:0]   stride [NUM_DIMS];
    logic [CNT_REG_W-1:0]  pos [NUM_DIMS];
    logic [OUT_ADDR_W-1:0] off [NUM_DIMS];
    placement_t            pending [$];
    int                    mismatches;
    int                    placed;
    int                    delivered;
    int                    transfers;

    function new();
      base = '0;
      size_lg = '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
        count[d] = CNT_REG_W'(1);
        stride[d] = (d == DIM_INNER) ? 1 : 0;
        pos[d] = '0;
        off[d] = '0;
      end
      mismatches = 0;
      placed = 0;
      delivered = 0;
      transfers = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DST_BASE:       base = val[BASE_W-1:0];
        REG_ELEM_SIZE_LOG2: size_lg = val[LG_W-1:0];
        REG_COUNT_OUTER:    count[DIM_OUTER] = val[CNT_REG_W-1:0];
        REG_COUNT_MIDDLE:   count[DIM_MIDDLE] = val[CNT_REG_W-1:0];
        REG_COUNT_INNER:    count[DIM_INNER] = val[CNT_REG_W-1:0];
        REG_STRIDE_OUTER:   stride[DIM_OUTER] = val[STRIDE_W-1:0];
        REG_STRIDE_MIDDLE:  stride[DIM_MIDDLE] = val[STRIDE_W-1:0];
        REG_STRIDE_INNER:   stride[DIM_INNER] = val[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_elem(logic [ELEM_W-1:0] d);
      placement_t            p;
      logic                  carry;
      logic [CNT_REG_W:0]    n;
      logic [OUT_ADDR_W-1:0] step;
      p.addr = base + off[DIM_OUTER] + off[DIM_MIDDLE] + off[DIM_INNER];
      p.data = d;
      carry = 1'b1;
      // inner first; a dimension only moves when everything inside it wrapped
      for (int k = 0; k < NUM_DIMS; k++) begin
        if (carry) begin
          n = (count[k] == '0) ? (CNT_REG_W+1)'(1) : {1'b0, count[k]};
          if ({1'b0, pos[k]} + 1 >= n) begin
            pos[k] = '0;
            off[k] = '0;
          end else begin
            step = OUT_ADDR_W'($signed(stride[k])) << size_lg;
            pos[k] = pos[k] + 1'b1;
            off[k] = off[k] + step;
            carry = 1'b0;
          end
        end
      end
      p.last = carry;
      if (carry) transfers++;
      placed++;
      pending.insert(pending.size(), p);
    endfunction

    function void check_placement(placement_t got);
      placement_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result with no request pending: addr=%h data=%h last=%b",
                   got.addr, got.data, got.last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.addr !== want.addr || got.data !== want.data || got.last !== want.last) begin
        if (mismatches < 10)
          $display("ERROR: element %0d: expected addr=%h data=%h last=%b, got addr=%h data=%h last=%b",
                   delivered, want.addr, want.data, want.last, got.addr, got.data, got.last);
        mismatches++;
      end
      delivered++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssag_elem_if   elem_ch ();
  ssag_result_if res_ch ();

  placement_scoreboard sb = new();

  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req;
  int hold_left;
  int idle_cycles;

  strided_scatter_address_generator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .elem      (elem_ch),
    .result    (res_ch)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (elem_ch.valid && elem_ch.ready) sb.accept_elem(elem_ch.elem_data);
      if (res_ch.valid && res_ch.ready)
        sb.check_placement({res_ch.dst_addr, res_ch.elem_out, res_ch.last_elem});
      if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("strided_scatter_address_generator_unit test failed");
          $finish;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [ELEM_W-1:0] corner_elem(int k);
    case (k % 6)
      0: return '0;
      1: return '1;
      2: return {32{2'b01}};
      3: return {32{2'b10}};
      4: return 64'h1;
      default: return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  function automatic logic [CNT_REG_W-1:0] rand_count();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return CNT_REG_W'($urandom);
      default: return CNT_REG_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [STRIDE_W-1:0] rand_stride();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  // Unused upper bits of the write data carry junk; the block must ignore them.
  function automatic logic [CFG_DATA_W-1:0] reg_value(logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    case (idx)
      REG_DST_BASE: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          default: return junk;
        endcase
      end
      REG_ELEM_SIZE_LOG2: return {junk[CFG_DATA_W-1:LG_W], LG_W'($urandom_range(3))};
      REG_COUNT_OUTER, REG_COUNT_MIDDLE, REG_COUNT_INNER:
        return {junk[CFG_DATA_W-1:CNT_REG_W], rand_count()};
      default: return {junk[CFG_DATA_W-1:STRIDE_W], rand_stride()};
    endcase
  endfunction

  // cfg_we stays high across back-to-back writes; caller lowers it.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic shuffle_regs();
    for (int r = REG_DST_BASE; r <= REG_STRIDE_INNER; r++)
      if ($urandom_range(1)) program_reg(CFG_IDX_W'(r), reg_value(CFG_IDX_W'(r)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_elems(int n, bit corners);
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        elem_ch.valid <= 1'b0;
        @(posedge clk);
      end
      elem_ch.valid <= 1'b1;
      if (corners || $urandom_range(9) == 0)
        elem_ch.elem_data <= corner_elem(corners ? i : $urandom_range(5));
      else
        elem_ch.elem_data <= {$urandom, $urandom};
      do @(posedge clk); while (!elem_ch.ready);
    end
    elem_ch.valid <= 1'b0;
  endtask

  // Sender stays quiet until every placement has come back.
  task automatic drain();
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    elem_ch.valid = 1'b0;
    elem_ch.elem_data = '0;
    res_ch.ready = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every element lands at zero and ends a transfer
    send_elems(3, 1'b1);
    drain();

    // top of the address space, widest elements, stride extremes both ways
    program_reg(REG_DST_BASE, 48'hFFFF_FFFF_FFF0);
    program_reg(REG_ELEM_SIZE_LOG2, 48'h3);
    program_reg(REG_COUNT_OUTER, 48'h2);
    program_reg(REG_COUNT_MIDDLE, 48'h2);
    program_reg(REG_COUNT_INNER, 48'h3);
    program_reg(REG_STRIDE_OUTER, 48'h0000_8000_0000);
    program_reg(REG_STRIDE_MIDDLE, 48'h0000_7FFF_FFFF);
    program_reg(REG_STRIDE_INNER, 48'h0000_FFFF_FFFF);
    cfg_we <= 1'b0;
    send_elems(17, 1'b1);
    drain();

    // mid-transfer change: inner count of zero acts as one, inner position past it wraps
    program_reg(REG_COUNT_INNER, '0);
    program_reg(REG_COUNT_MIDDLE, 48'hFFFF);
    program_reg(REG_COUNT_OUTER, '0);
    program_reg(REG_ELEM_SIZE_LOG2, '0);
    program_reg(REG_STRIDE_INNER, 48'h1);
    cfg_we <= 1'b0;
    send_elems(5, 1'b1);
    drain();

    phase = 0;
    while (sb.placed < TARGET_ELEMS) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      shuffle_regs();
      if (phase % 7 == 2) begin
        // result side blocks while requests keep coming, so the input backs up
        tx_idle_pct = 0;
        hold_req = 1'b1;
        send_elems(40, 1'b0);
      end else begin
        send_elems($urandom_range(10, 60), 1'b0);
      end
      drain();
      phase++;
    end

    $display("Placed %0d elements over %0d random register settings, %0d transfer ends seen.",
             sb.placed, phase, sb.transfers);
    $display("Idle mixes: none, sender-only, receiver-only, both, plus long result hold-offs.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("strided_scatter_address_generator_unit test passed");
    end else begin
      $display("strided_scatter_address_generator_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ssag_pkg.sv
rtl/ssag_elem_if.sv
rtl/ssag_result_if.sv
rtl/ssag_cell.sv
rtl/strided_scatter_address_generator_unit.sv
tb/sv/strided_scatter_address_generator_unit_test.sv
